/* src/rrpf_pkg.sv */
// ----------------------------------------------------------------------------
// rrpf_pkg
// Shared widths, limits and handshake structs of the repulsive r^-12 pair
// force block.
// ----------------------------------------------------------------------------
package rrpf_pkg;

    // Wide datapath: s^7 needs 441 bits, shifted divisor up to 488 bits
    localparam int W      = 512;
    localparam int LIMB_W = 32;
    localparam int LIMBS  = W / LIMB_W;

    // Fixed-point scaling of the energy and force quotients
    localparam int E_SHIFT = 192;
    localparam int F_SHIFT = 208;
    localparam int E_QBITS = 48;
    localparam int F_QBITS = 47;

    // Saturation limits
    localparam logic [48:0]        EMAX = 49'h1_FFFF_FFFF_FFFF;
    localparam logic signed [49:0] FMAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] FMIN = -50'sh0_8000_0000_0000;
    localparam logic [15:0]        CNT_MAX = 16'hFFFF;

    localparam int NUM_TYPES_DEF = 2;

    // Configuration register indexes
    localparam logic [2:0] CFG_CUTOFF = 3'd0;
    localparam logic [2:0] CFG_C00    = 3'd1;
    localparam logic [2:0] CFG_C01    = 3'd2;
    localparam logic [2:0] CFG_C10    = 3'd3;
    localparam logic [2:0] CFG_C11    = 3'd4;

    // Divider request
    typedef struct packed {
        logic start;
        logic force_mode;
    } div_req_t;

    // Status of a shared unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

/* src/rrpf_bigmul.sv */
// ----------------------------------------------------------------------------
// rrpf_bigmul
// Wide by 64-bit multiplier built on one registered 32x32 multiplier,
// Horner scheme over the limbs of the wide operand, one limb at a time.
// ----------------------------------------------------------------------------
module rrpf_bigmul (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [rrpf_pkg::W-1:0]   a_in,
    input  logic [63:0]              m_in,
    output logic [rrpf_pkg::W-1:0]   p_out,
    output rrpf_pkg::unit_status_t   status
);
    localparam int CW = $clog2(rrpf_pkg::LIMBS);

    typedef enum logic [1:0] {ST_IDLE, ST_HI, ST_MID, ST_LO} state_t;

    state_t                  state_reg;
    logic [rrpf_pkg::W-1:0]  a_reg;
    logic [rrpf_pkg::W-1:0]  p_reg;
    logic [63:0]             m_reg;
    logic [63:0]             prod_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    done_reg;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;

    // Top limb of the shifting operand against the selected half of m
    assign mul_a = a_reg[rrpf_pkg::W-1 -: 32];
    assign mul_b = (state_reg == ST_HI) ? m_reg[63:32] : m_reg[31:0];

    // Shared 32x32 multiplier, registered output
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        a_reg     <= a_in;
                        m_reg     <= m_in;
                        p_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_HI;
                    end
                end
                ST_HI: begin
                    state_reg <= ST_MID;
                end
                ST_MID: begin
                    p_reg     <= (p_reg + {{(rrpf_pkg::W-64){1'b0}}, prod_reg}) << 32;
                    state_reg <= ST_LO;
                end
                ST_LO: begin
                    p_reg   <= p_reg + {{(rrpf_pkg::W-64){1'b0}}, prod_reg};
                    a_reg   <= a_reg << 32;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(rrpf_pkg::LIMBS - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_HI;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign p_out       = p_reg;
    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = done_reg;

endmodule

/* src/rrpf_divider.sv */
// ----------------------------------------------------------------------------
// rrpf_divider
// Restoring bit-serial divider with saturation, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rrpf_divider (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rrpf_pkg::div_req_t       req,
    input  logic [rrpf_pkg::W-1:0]   num,
    input  logic [rrpf_pkg::W-1:0]   den,
    output logic [47:0]              quot,
    output rrpf_pkg::unit_status_t   status
);
    typedef enum logic [1:0] {ST_IDLE, ST_CHK, ST_RUN} state_t;

    state_t                  state_reg;
    logic [rrpf_pkg::W-1:0]  r_reg;
    logic [rrpf_pkg::W-1:0]  t_reg;
    logic [47:0]             q_reg;
    logic [5:0]              cnt_reg;
    logic                    fmode_reg;
    logic                    done_reg;
    logic                    ge;
    logic [rrpf_pkg::W-1:0]  diff;

    // Shared compare and subtract
    assign diff = r_reg - t_reg;
    assign ge   = (r_reg >= t_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (req.start) begin
                        r_reg     <= num;
                        t_reg     <= req.force_mode ? (den << rrpf_pkg::F_QBITS)
                                                    : (den << rrpf_pkg::E_QBITS);
                        fmode_reg <= req.force_mode;
                        q_reg     <= '0;
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    // Quotient too large for its field: saturate
                    if (ge) begin
                        q_reg     <= fmode_reg ? {1'b0, {47{1'b1}}} : {48{1'b1}};
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        t_reg     <= t_reg >> 1;
                        cnt_reg   <= fmode_reg ? 6'(rrpf_pkg::F_QBITS - 1)
                                               : 6'(rrpf_pkg::E_QBITS - 1);
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (ge) begin
                        r_reg <= diff;
                    end
                    q_reg <= {q_reg[46:0], ge};
                    t_reg <= t_reg >> 1;
                    if (cnt_reg == 6'd0) begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign quot        = q_reg;
    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = done_reg;

endmodule

/* src/repulsive_r12_pair_force_top.sv */
// ----------------------------------------------------------------------------
// repulsive_r12_pair_force_top
// Repulsive r^-12 pair energy and force accumulator, one candidate pair per
// transaction, with exact fixed-point quotients.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one candidate pair per transaction (positions, kinds, end
//   marks). s_ready is high only while the block is idle.
//   m_* channel: one result per atom, sent at the pair with last_pair or
//   last_frame set; frame_energy and frame_done are valid at frame end.
//   cfg_* channel: register writes, always ready, to be done while idle.
// Sequence:
//   A pair that is skipped by the cutoff uses three squares on the shared
//   wide multiplier. A counted pair adds nine more wide multiplies and four
//   divisions, all on one 32x32 multiplier and one bit-serial divider. Items
//   are handled one at a time.
// Reset: synchronous, active low; clears configuration, control state, accumulators and output valid.
// Stall: a result waits in the output register; the next item is accepted,
//   but its own result is held back until the previous one is taken.
// ----------------------------------------------------------------------------
module repulsive_r12_pair_force_top #(
    parameter int NUM_TYPES = rrpf_pkg::NUM_TYPES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // pair input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_atom_x,
    input  logic signed [31:0] s_atom_y,
    input  logic signed [31:0] s_atom_z,
    input  logic signed [31:0] s_image_x,
    input  logic signed [31:0] s_image_y,
    input  logic signed [31:0] s_image_z,
    input  logic               s_atom_kind,
    input  logic               s_image_kind,
    input  logic               s_last_pair,
    input  logic               s_last_frame,
    // result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_force_x,
    output logic signed [47:0] m_force_y,
    output logic signed [47:0] m_force_z,
    output logic [15:0]        m_neighbor_count,
    output logic [47:0]        m_frame_energy,
    output logic               m_frame_done,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    localparam int  W         = rrpf_pkg::W;
    localparam logic KIND_MASK = (NUM_TYPES > 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ_GO, ST_SQ_WAIT, ST_CHECK, ST_POW_GO, ST_POW_WAIT,
        ST_EN_GO, ST_EN_WAIT, ST_FM_GO, ST_FM_WAIT, ST_FD_GO, ST_FD_WAIT,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    logic [62:0]          cutoff_reg;
    logic [47:0]          coef00_reg, coef01_reg, coef10_reg, coef11_reg;
    logic [31:0]          mag_reg [3];
    logic [2:0]           neg_reg;
    logic [1:0]           axis_reg;
    logic [65:0]          rsq_reg;
    logic [63:0]          s_reg;
    logic [2:0]           pow_k_reg;
    logic [W-1:0]         pow_reg;
    logic [W-1:0]         s6_reg;
    logic [47:0]          coef_reg;
    logic                 lp_reg, lf_reg;
    logic signed [47:0]   facc_reg [3];
    logic [48:0]          eacc_reg;
    logic [15:0]          cnt_reg;
    logic                 m_valid_reg;
    logic signed [47:0]   m_fx_reg, m_fy_reg, m_fz_reg;
    logic [15:0]          m_cnt_reg;
    logic [47:0]          m_en_reg;
    logic                 m_done_reg;

    logic                 bm_start;
    logic [W-1:0]         bm_a;
    logic [63:0]          bm_m;
    logic [W-1:0]         bm_p;
    rrpf_pkg::unit_status_t bm_st;
    rrpf_pkg::div_req_t   dv_req;
    logic [W-1:0]         dv_num;
    logic [W-1:0]         dv_den;
    logic [47:0]          dv_q;
    rrpf_pkg::unit_status_t dv_st;

    logic signed [32:0]   dx, dy, dz;
    logic [1:0]           kind_sel;
    logic [47:0]          coef_mux;
    logic [35:0]          mag12;
    logic signed [48:0]   fpart;
    logic signed [49:0]   fsum;
    logic signed [47:0]   fsat;
    logic [49:0]          esum;
    logic                 counted;
    logic                 out_free;
    logic                 out_load;

    // Offsets of the accepted pair
    assign dx = 33'(s_atom_x) - 33'(s_image_x);
    assign dy = 33'(s_atom_y) - 33'(s_image_y);
    assign dz = 33'(s_atom_z) - 33'(s_image_z);

    // Coefficient lookup with kind clamp
    assign kind_sel = {s_atom_kind & KIND_MASK, s_image_kind & KIND_MASK};
    always_comb begin
        unique case (kind_sel)
            2'b00:   coef_mux = coef00_reg;
            2'b01:   coef_mux = coef01_reg;
            2'b10:   coef_mux = coef10_reg;
            default: coef_mux = coef11_reg;
        endcase
    end

    // 12*|d| for the current axis
    assign mag12 = {1'b0, mag_reg[axis_reg], 3'b000} + {2'b00, mag_reg[axis_reg], 2'b00};

    // Wide multiplier operands
    always_comb begin
        bm_start = 1'b0;
        bm_a     = '0;
        bm_m     = '0;
        case (state_reg)
            ST_SQ_GO: begin
                bm_start = 1'b1;
                bm_a     = W'(mag_reg[axis_reg]);
                bm_m     = 64'(mag_reg[axis_reg]);
            end
            ST_POW_GO: begin
                bm_start = 1'b1;
                bm_a     = pow_reg;
                bm_m     = s_reg;
            end
            ST_FM_GO: begin
                bm_start = 1'b1;
                bm_a     = W'(coef_reg);
                bm_m     = 64'(mag12);
            end
            default: ;
        endcase
    end

    // Divider operands
    always_comb begin
        dv_req.start      = (state_reg == ST_EN_GO) || (state_reg == ST_FD_GO);
        dv_req.force_mode = (state_reg == ST_FD_GO);
        if (state_reg == ST_FD_GO) begin
            dv_num = bm_p << rrpf_pkg::F_SHIFT;
            dv_den = pow_reg;
        end else begin
            dv_num = W'(coef_reg) << rrpf_pkg::E_SHIFT;
            dv_den = s6_reg;
        end
    end

    rrpf_bigmul u_bigmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bm_start),
        .a_in    (bm_a),
        .m_in    (bm_m),
        .p_out   (bm_p),
        .status  (bm_st)
    );

    rrpf_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dv_req),
        .num     (dv_num),
        .den     (dv_den),
        .quot    (dv_q),
        .status  (dv_st)
    );

    // Cutoff test
    assign counted = (rsq_reg[65:64] == 2'b00) && (rsq_reg != '0) &&
                     (rsq_reg[63:0] < {1'b0, cutoff_reg});

    // Saturating accumulate of one force component
    assign fpart = neg_reg[axis_reg] ? -$signed({2'b00, dv_q[46:0]})
                                     :  $signed({2'b00, dv_q[46:0]});
    assign fsum  = 50'(facc_reg[axis_reg]) + 50'(fpart);
    assign fsat  = (fsum > rrpf_pkg::FMAX) ? 48'(rrpf_pkg::FMAX) :
                   (fsum < rrpf_pkg::FMIN) ? 48'(rrpf_pkg::FMIN) : fsum[47:0];

    // Saturating energy accumulate
    assign esum = {1'b0, eacc_reg} + {2'b00, dv_q};

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_FINISH) && (lp_reg || lf_reg) && out_free;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= '0;
            coef00_reg <= '0;
            coef01_reg <= '0;
            coef10_reg <= '0;
            coef11_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rrpf_pkg::CFG_CUTOFF: cutoff_reg <= cfg_data[62:0];
                rrpf_pkg::CFG_C00:    coef00_reg <= cfg_data[47:0];
                rrpf_pkg::CFG_C01:    coef01_reg <= cfg_data[47:0];
                rrpf_pkg::CFG_C10:    coef10_reg <= cfg_data[47:0];
                rrpf_pkg::CFG_C11:    coef11_reg <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // Sequencer, accumulators and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= '0;
            pow_k_reg   <= '0;
            facc_reg[0] <= '0;
            facc_reg[1] <= '0;
            facc_reg[2] <= '0;
            eacc_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mag_reg[0] <= dx[32] ? 32'(-dx) : dx[31:0];
                        mag_reg[1] <= dy[32] ? 32'(-dy) : dy[31:0];
                        mag_reg[2] <= dz[32] ? 32'(-dz) : dz[31:0];
                        neg_reg    <= {dz[32], dy[32], dx[32]};
                        coef_reg   <= coef_mux;
                        lp_reg     <= s_last_pair;
                        lf_reg     <= s_last_frame;
                        rsq_reg    <= '0;
                        axis_reg   <= '0;
                        state_reg  <= ST_SQ_GO;
                    end
                end
                ST_SQ_GO: state_reg <= ST_SQ_WAIT;
                ST_SQ_WAIT: begin
                    if (bm_st.done) begin
                        rsq_reg <= rsq_reg + {2'b00, bm_p[63:0]};
                        if (axis_reg == 2'd2) begin
                            state_reg <= ST_CHECK;
                        end else begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= ST_SQ_GO;
                        end
                    end
                end
                ST_CHECK: begin
                    s_reg     <= rsq_reg[63:0];
                    pow_reg   <= W'(rsq_reg[63:0]);
                    pow_k_reg <= 3'd1;
                    state_reg <= counted ? ST_POW_GO : ST_FINISH;
                end
                ST_POW_GO: state_reg <= ST_POW_WAIT;
                ST_POW_WAIT: begin
                    if (bm_st.done) begin
                        pow_reg   <= bm_p;
                        pow_k_reg <= pow_k_reg + 1'b1;
                        if (pow_k_reg == 3'd5) begin
                            s6_reg <= bm_p;
                        end
                        state_reg <= (pow_k_reg == 3'd6) ? ST_EN_GO : ST_POW_GO;
                    end
                end
                ST_EN_GO: state_reg <= ST_EN_WAIT;
                ST_EN_WAIT: begin
                    if (dv_st.done) begin
                        eacc_reg  <= (esum > 50'(rrpf_pkg::EMAX)) ? rrpf_pkg::EMAX
                                                                  : esum[48:0];
                        axis_reg  <= '0;
                        state_reg <= ST_FM_GO;
                    end
                end
                ST_FM_GO: state_reg <= ST_FM_WAIT;
                ST_FM_WAIT: begin
                    if (bm_st.done) begin
                        state_reg <= ST_FD_GO;
                    end
                end
                ST_FD_GO: state_reg <= ST_FD_WAIT;
                ST_FD_WAIT: begin
                    if (dv_st.done) begin
                        facc_reg[axis_reg] <= fsat;
                        if (axis_reg == 2'd2) begin
                            if (cnt_reg != rrpf_pkg::CNT_MAX) begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                            state_reg <= ST_FINISH;
                        end else begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= ST_FM_GO;
                        end
                    end
                end
                ST_FINISH: begin
                    if (!lp_reg && !lf_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        m_fx_reg    <= facc_reg[0];
                        m_fy_reg    <= facc_reg[1];
                        m_fz_reg    <= facc_reg[2];
                        m_cnt_reg   <= cnt_reg;
                        m_en_reg    <= lf_reg ? eacc_reg[48:1] : '0;
                        m_done_reg  <= lf_reg;
                        facc_reg[0] <= '0;
                        facc_reg[1] <= '0;
                        facc_reg[2] <= '0;
                        cnt_reg     <= '0;
                        if (lf_reg) begin
                            eacc_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_force_x        = m_fx_reg;
    assign m_force_y        = m_fy_reg;
    assign m_force_z        = m_fz_reg;
    assign m_neighbor_count = m_cnt_reg;
    assign m_frame_energy   = m_en_reg;
    assign m_frame_done     = m_done_reg;

    // An accepted pair keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

    // Energy field is zero unless the result closes a frame
    a_energy_frame_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_done |-> m_frame_energy == 48'd0)
        else $error("energy on a non-closing result");

    // Multiplier completions only land in waiting states
    a_bm_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        bm_st.done |-> (state_reg == ST_SQ_WAIT) || (state_reg == ST_POW_WAIT) ||
                       (state_reg == ST_FM_WAIT))
        else $error("multiplier done in wrong state");

    // The two shared units never run at once
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_st.busy |-> !bm_st.busy)
        else $error("multiplier and divider both busy");

endmodule
